/* rtl/core/pkhs_pkg.sv */
// ----------------------------------------------------------------------------
// pkhs_pkg
// Types, constants and hash functions shared by the k-mer hash sampler.
// ----------------------------------------------------------------------------
package pkhs_pkg;

    localparam int CODE_W     = 4;
    localparam int KLEN_W     = 3;
    localparam int SBITS_W    = 5;
    localparam int WIN_W      = 28;
    localparam int RUN_W      = 3;
    localparam int POS_W      = 31;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CODE_W-1:0]  CODE_BREAK = 4'd14;
    localparam logic [RUN_W-1:0]   RUN_TOP    = 3'd7;
    localparam logic [POS_W-1:0]   POS_TOP    = 31'h7FFF_FFFF;

    localparam logic [KLEN_W-1:0]  KLEN_RESET  = 3'd6;
    localparam logic [SBITS_W-1:0] SBITS_RESET = 5'd1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KMER_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_BITS = 1'b1;

    // shift amounts of the shift-add-xor hash
    localparam int SH_A = 15;
    localparam int SH_B = 10;
    localparam int SH_C = 3;
    localparam int SH_D = 6;
    localparam int SH_E = 11;
    localparam int SH_F = 16;

    typedef struct packed {
        logic [CODE_W-1:0] residue_code;
        logic              start_of_sequence;
    } in_word_t;

    typedef struct packed {
        logic [WIN_W-1:0] sample_hash;
        logic [POS_W-1:0] sample_position;
    } out_word_t;

    typedef struct packed {
        logic [KLEN_W-1:0]  kmer_length;
        logic [SBITS_W-1:0] sample_bits;
    } cfg_t;

    // k-mer that reached full length, waiting to be hashed
    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [POS_W-1:0] position;
    } cand_t;

    function automatic logic [WIN_W-1:0] kmer_mask(input logic [KLEN_W-1:0] kl);
        logic [WIN_W:0] one_hot;
        one_hot = (WIN_W+1)'(1) << {kl, 2'b00};
        return WIN_W'(one_hot - (WIN_W+1)'(1));
    endfunction

    // all ones once sample_bits reaches the hash width
    function automatic logic [WIN_W-1:0] sample_mask(input logic [SBITS_W-1:0] sb);
        logic [WIN_W:0] one_hot;
        one_hot = (WIN_W+1)'(1) << sb;
        return WIN_W'(one_hot - (WIN_W+1)'(1));
    endfunction

    // first two add/xor rounds
    function automatic logic [WIN_W-1:0] hash_front(input logic [WIN_W-1:0] v_in,
                                                    input logic [WIN_W-1:0] m);
        logic [WIN_W-1:0] v;
        v = (v_in + ~(v_in << SH_A)) & m;
        v = v ^ (v >> SH_B);
        v = (v + (v << SH_C)) & m;
        v = v ^ (v >> SH_D);
        return v;
    endfunction

    // last add/xor round
    function automatic logic [WIN_W-1:0] hash_back(input logic [WIN_W-1:0] v_in,
                                                   input logic [WIN_W-1:0] m);
        logic [WIN_W-1:0] v;
        v = (v_in + ~(v_in << SH_E)) & m;
        v = v ^ (v >> SH_F);
        return v;
    endfunction

endpackage

/* rtl/core/pkhs_front.sv */
// ----------------------------------------------------------------------------
// pkhs_front
// Input register: k-mer window, run length and position tracking.
// ----------------------------------------------------------------------------
module pkhs_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  pkhs_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  pkhs_pkg::in_word_t s_data,
    output logic              cand_valid,
    input  logic              cand_ready,
    output pkhs_pkg::cand_t   cand
);

    logic [pkhs_pkg::WIN_W-1:0] window_reg, window_next, window_base;
    logic [pkhs_pkg::RUN_W-1:0] run_reg, run_next, run_base;
    logic [pkhs_pkg::POS_W-1:0] pos_reg, pos_next, pos_base;
    logic                       cand_valid_reg;
    pkhs_pkg::cand_t            cand_reg;
    logic                       eligible;
    logic                       accept;

    assign s_ready    = !cand_valid_reg || cand_ready;
    assign accept     = s_valid && s_ready;
    assign cand_valid = cand_valid_reg;
    assign cand       = cand_reg;

    always_comb begin
        window_base = s_data.start_of_sequence ? '0 : window_reg;
        run_base    = s_data.start_of_sequence ? '0 : run_reg;
        pos_base    = s_data.start_of_sequence ? '0 : pos_reg;

        if (s_data.residue_code < pkhs_pkg::CODE_BREAK) begin
            window_next = ((window_base << 4)
                          | pkhs_pkg::WIN_W'(s_data.residue_code))
                          & pkhs_pkg::kmer_mask(cfg.kmer_length);
            run_next    = (run_base == pkhs_pkg::RUN_TOP) ? run_base
                                                          : run_base + 3'd1;
            eligible    = (run_next >= cfg.kmer_length);
        end else begin
            window_next = '0;
            run_next    = '0;
            eligible    = 1'b0;
        end

        pos_next = (pos_base == pkhs_pkg::POS_TOP) ? pos_base : pos_base + 31'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= '0;
            run_reg        <= '0;
            pos_reg        <= '0;
            cand_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                window_reg     <= window_next;
                run_reg        <= run_next;
                pos_reg        <= pos_next;
                cand_valid_reg <= eligible;
            end else if (cand_ready) begin
                cand_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cand_reg.window   <= window_next;
            cand_reg.position <= pos_base;
        end
    end

endmodule

/* rtl/core/pkhs_hash.sv */
// ----------------------------------------------------------------------------
// pkhs_hash
// Two-stage masked hash, sample test and output register.
// ----------------------------------------------------------------------------
module pkhs_hash (
    input  logic               aclk,
    input  logic               aresetn,
    input  pkhs_pkg::cfg_t     cfg,
    input  logic               cand_valid,
    output logic               cand_ready,
    input  pkhs_pkg::cand_t    cand,
    output logic               m_valid,
    input  logic               m_ready,
    output pkhs_pkg::out_word_t m_data
);

    logic [pkhs_pkg::WIN_W-1:0] kmask;
    logic [pkhs_pkg::WIN_W-1:0] mid_hash_reg;
    logic [pkhs_pkg::POS_W-1:0] mid_pos_reg;
    logic                       mid_valid_reg;
    logic [pkhs_pkg::WIN_W-1:0] hash_full;
    logic                       pass;
    logic                       out_free;
    logic                       mid_go;
    logic                       m_valid_reg;
    pkhs_pkg::out_word_t        m_data_reg;

    assign kmask      = pkhs_pkg::kmer_mask(cfg.kmer_length);
    assign hash_full  = pkhs_pkg::hash_back(mid_hash_reg, kmask);
    assign pass       = (hash_full & pkhs_pkg::sample_mask(cfg.sample_bits)) == '0;
    assign out_free   = !m_valid_reg || m_ready;
    // a word that fails the sample test leaves without needing the output slot
    assign mid_go     = mid_valid_reg && (out_free || !pass);
    assign cand_ready = !mid_valid_reg || mid_go;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cand_valid && cand_ready) begin
                mid_valid_reg <= 1'b1;
            end else if (mid_go) begin
                mid_valid_reg <= 1'b0;
            end

            if (mid_go && pass) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cand_valid && cand_ready) begin
            mid_hash_reg <= pkhs_pkg::hash_front(cand.window, kmask);
            mid_pos_reg  <= cand.position;
        end
        if (mid_go && pass) begin
            m_data_reg.sample_hash     <= hash_full >> cfg.sample_bits;
            m_data_reg.sample_position <= mid_pos_reg;
        end
    end

endmodule

/* rtl/core/protein_kmer_hash_sampler.sv */
// ----------------------------------------------------------------------------
// protein_kmer_hash_sampler
// Modimizer sketch over a stream of reduced amino-acid codes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one residue word per cycle while s_ready (code 0..13, 14/15 break
//   the k-mer; start_of_sequence restarts window, run length and position).
//   m_* channel returns a sample word (hash >> sample_bits, position) for each
//   full-length k-mer whose low sample_bits hash bits are zero; other residues
//   give no word.
//   cfg_* writes kmer_length (index 0) or sample_bits (index 1); write only
//   while no words are in flight.
// Path: a residue taken into the input register passes the first hash stage
//   and then the output register before its sample appears on m_valid.
// Throughput: one residue per cycle unless stalled; each stage holds one word
//   and moves on whenever the stage after it is empty or draining.
// Reset: clears window, run length, position and all valid flags;
//   kmer_length returns to 6, sample_bits to 1.
// Stall: with m_ready low the output word holds and up to two more k-mers
//   wait in the pipeline; s_ready drops only when all stages are full.
// ----------------------------------------------------------------------------
module protein_kmer_hash_sampler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pkhs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pkhs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pkhs_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pkhs_pkg::out_word_t                 m_data
);

    pkhs_pkg::cfg_t  cfg_reg;
    logic            cand_valid;
    logic            cand_ready;
    pkhs_pkg::cand_t cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kmer_length <= pkhs_pkg::KLEN_RESET;
            cfg_reg.sample_bits <= pkhs_pkg::SBITS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pkhs_pkg::REG_KMER_LENGTH: begin
                    cfg_reg.kmer_length <= cfg_wdata[pkhs_pkg::KLEN_W-1:0];
                end
                pkhs_pkg::REG_SAMPLE_BITS: begin
                    cfg_reg.sample_bits <= cfg_wdata[pkhs_pkg::SBITS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pkhs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand)
    );

    pkhs_hash u_hash (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* rtl/core/pkhs_checker.sv */
// ----------------------------------------------------------------------------
// pkhs_checker
// Port-level checks for the k-mer hash sampler, bound to the top level.
// ----------------------------------------------------------------------------
module pkhs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic [pkhs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [pkhs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input pkhs_pkg::out_word_t             m_data
);

    logic [pkhs_pkg::KLEN_W-1:0]  klen_reg;
    logic [pkhs_pkg::SBITS_W-1:0] sbits_reg;
    logic [4:0]                   win_bits;
    logic [4:0]                   hash_bits;

    // shadow of the configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg  <= pkhs_pkg::KLEN_RESET;
            sbits_reg <= pkhs_pkg::SBITS_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == pkhs_pkg::REG_KMER_LENGTH) begin
                klen_reg <= cfg_wdata[pkhs_pkg::KLEN_W-1:0];
            end else begin
                sbits_reg <= cfg_wdata[pkhs_pkg::SBITS_W-1:0];
            end
        end
    end

    assign win_bits  = {klen_reg, 2'b00};
    assign hash_bits = (sbits_reg >= win_bits) ? 5'd0 : win_bits - sbits_reg;

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // with the output slot empty the whole pipeline can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // sample fits in the window width less the dropped low bits
    a_hash_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.sample_hash >> hash_bits) == '0)
        else $error("sample hash wider than the k-mer window allows");

endmodule

bind protein_kmer_hash_sampler pkhs_checker u_pkhs_checker (.*);
